FILE: rtl/core/lice_pkg.sv
// shared types, constants and helpers of the inverse-log calibration pipeline
`timescale 1ns / 1ps
`default_nettype none
package lice_pkg;

	// register indexes of the configuration port
	localparam int REG_W = 3;
	localparam logic [REG_W-1:0] REG_X_OFFSET = 3'd0;
	localparam logic [REG_W-1:0] REG_COEF_0   = 3'd1;
	localparam logic [REG_W-1:0] REG_COEF_1   = 3'd2;
	localparam logic [REG_W-1:0] REG_COEF_2   = 3'd3;
	localparam logic [REG_W-1:0] REG_COEF_3   = 3'd4;
	localparam int NCOEF = 4;

	// datapath widths
	localparam int CH_W   = 16;
	localparam int OFF_W  = 24;
	localparam int CFG_W  = 32;
	localparam int D_W    = 26;
	localparam int AD_W   = 25;
	localparam int Q_W    = 33;
	localparam int PMAG_W = 56;
	localparam int CMAG_W = 32;
	localparam int ACC_W  = 59;
	localparam int ARG_W  = 30;
	localparam int VAL_W  = 32;

	// fixed-point constants
	localparam logic [Q_W-1:0]    U_MAX    = 33'h0_FFFF_FFFF;
	localparam logic [Q_W-1:0]    U_NUM    = 33'h1_0000_0000;
	localparam logic [PMAG_W-1:0] PROD_LIM = 56'h80_0000_0000_0000;
	localparam logic [PMAG_W-1:0] Q24_ONE  = 56'h00_0000_0100_0000;
	localparam logic signed [ACC_W-1:0] ARG_LIM = 59'sh000_0000_1000_0000;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [9:0]  LN2_RECIP = 10'd369;

	// values that travel along the polynomial steps
	typedef struct packed {
		logic                     sat;
		logic [Q_W-1:0]           u_mag;
		logic                     u_neg;
		logic [PMAG_W-1:0]        p_mag;
		logic                     p_neg;
		logic signed [ACC_W-1:0]  acc;
		logic [PMAG_W-1:0]        t_mag;
		logic                     t_neg;
	} poly_t;

	// add a sign-magnitude term to the running sum
	function automatic logic signed [ACC_W-1:0] add_term(
		input logic signed [ACC_W-1:0] acc,
		input logic [PMAG_W-1:0]       mag,
		input logic                    neg
	);
		logic signed [ACC_W-1:0] tv;
		tv = $signed({{(ACC_W-PMAG_W){1'b0}}, mag});
		return neg ? acc - tv : acc + tv;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/log_inverse_calibration_eval.sv
// Throughput: one transaction per cycle while the output is not stalled; the whole pipeline advances together.
// The depth is set by the 33 bit-per-stage reciprocal divider and the 15 series terms of exp.
// A stalled result holds the pipeline; empty output lets new input in.
// Reset clears valid bits and configuration registers asynchronously; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module log_inverse_calibration_eval #(
	parameter int NUM_TERMS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lice_pkg::REG_W-1:0]     cfg_index,
	input  logic [lice_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lice_pkg::CH_W-1:0]      channel,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lice_pkg::VAL_W-1:0]     value,
	output logic                           overflow
);
	import lice_pkg::*;

	localparam int NSTEP = ((NUM_TERMS < NCOEF) ? NUM_TERMS : NCOEF) - 1;

	logic signed [OFF_W-1:0] x_offset_q;
	logic signed [CFG_W-1:0] coef0_q;
	logic [CMAG_W-1:0]       coef_mag_q [1:NCOEF-1];
	logic                    coef_neg_q [1:NCOEF-1];
	logic [CMAG_W-1:0]       data_mag;

	logic                    en;
	logic                    rv;
	logic [Q_W-1:0]          u_mag;
	logic                    u_neg;
	logic                    rsat;

	poly_t                   chain [0:NSTEP];
	logic                    chv   [0:NSTEP];

	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ARG_W-1:0] arg_s;
	logic                    sat_s;
	logic                    v_c;

	// whole pipeline moves unless a result is waiting
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// configuration registers, coefficients one to three kept as sign and magnitude
	assign data_mag = cfg_data[CFG_W-1] ? (~cfg_data + 32'd1) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= '0;
			coef0_q    <= '0;
			for (int k = 1; k < NCOEF; k++) begin
				coef_mag_q[k] <= '0;
				coef_neg_q[k] <= 1'b0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_X_OFFSET: x_offset_q <= $signed(cfg_data[OFF_W-1:0]);
				REG_COEF_0:   coef0_q    <= $signed(cfg_data);
				REG_COEF_1: begin
					coef_mag_q[1] <= data_mag;
					coef_neg_q[1] <= cfg_data[CFG_W-1];
				end
				REG_COEF_2: begin
					coef_mag_q[2] <= data_mag;
					coef_neg_q[2] <= cfg_data[CFG_W-1];
				end
				REG_COEF_3: begin
					coef_mag_q[3] <= data_mag;
					coef_neg_q[3] <= cfg_data[CFG_W-1];
				end
				default: ;
			endcase
		end
	end

	// reciprocal of channel minus offset
	lice_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (in_valid && in_ready),
		.channel  (channel),
		.x_offset (x_offset_q),
		.v_out    (rv),
		.u_mag    (u_mag),
		.u_neg    (u_neg),
		.sat      (rsat)
	);

	// polynomial start: p = 1, sum = c0
	always_comb begin
		chain[0].sat   = rsat;
		chain[0].u_mag = u_mag;
		chain[0].u_neg = u_neg;
		chain[0].p_mag = Q24_ONE;
		chain[0].p_neg = 1'b0;
		chain[0].acc   = ACC_W'(coef0_q);
		chain[0].t_mag = '0;
		chain[0].t_neg = 1'b0;
	end
	assign chv[0] = rv;

	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		lice_term u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (chv[k-1]),
			.in     (chain[k-1]),
			.c_mag  (coef_mag_q[k]),
			.c_neg  (coef_neg_q[k]),
			.v_out  (chv[k]),
			.out    (chain[k])
		);
	end

	// last term and clamp to the exp argument range
	assign acc_sum = add_term(chain[NSTEP].acc, chain[NSTEP].t_mag, chain[NSTEP].t_neg);

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s <= chain[NSTEP].sat;
			if (acc_sum > ARG_LIM)
				arg_s <= ARG_W'(ARG_LIM);
			else if (acc_sum < -ARG_LIM)
				arg_s <= ARG_W'(-ARG_LIM);
			else
				arg_s <= acc_sum[ARG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_c <= 1'b0;
		else if (en)
			v_c <= chv[NSTEP];
	end

	lice_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_c),
		.arg      (arg_s),
		.sat_in   (sat_s),
		.v_out    (out_valid),
		.value    (value),
		.overflow (overflow)
	);

`ifndef NO_ASSERTIONS
	// a positive reciprocal never exceeds the largest value
	assert property (@(posedge clk) disable iff (!arst_n)
		rv && !u_neg |-> !u_mag[Q_W-1])
		else $error("positive reciprocal above saturation limit");

	// a saturated reciprocal is the largest positive value
	assert property (@(posedge clk) disable iff (!arst_n)
		rv && rsat |-> (!u_neg && u_mag == U_MAX))
		else $error("saturated reciprocal has wrong value");

	// the exp argument stays within the clamp range
	assert property (@(posedge clk) disable iff (!arst_n)
		v_c |-> (arg_s <= ARG_W'(ARG_LIM)) && (arg_s >= ARG_W'(-ARG_LIM)))
		else $error("exp argument outside clamp range");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/lice_mul.sv
// two-stage rounded and saturated Q.24 magnitude multiplier
`timescale 1ns / 1ps
`default_nettype none
module lice_mul (
	input  logic                       clk,
	input  logic                       en,
	input  logic [lice_pkg::PMAG_W-1:0] a_mag,
	input  logic                       a_neg,
	input  logic [lice_pkg::Q_W-1:0]    b_mag,
	input  logic                       b_neg,
	output logic [lice_pkg::PMAG_W-1:0] p_mag,
	output logic                       p_neg
);
	import lice_pkg::*;

	localparam int HALF = PMAG_W / 2;
	localparam int PP_W = HALF + Q_W;
	localparam int FULL_W = PMAG_W + Q_W;

	logic [PP_W-1:0]   pl_s1;
	logic [PP_W-1:0]   ph_s1;
	logic              neg_s1;
	logic [FULL_W-1:0] full;
	logic [FULL_W-25:0] rnd;

	// partial products of the two halves of a
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= PP_W'(a_mag[HALF-1:0]) * PP_W'(b_mag);
			ph_s1  <= PP_W'(a_mag[PMAG_W-1:HALF]) * PP_W'(b_mag);
			neg_s1 <= a_neg ^ b_neg;
		end
	end

	// combine, round half away from zero, saturate
	assign full = FULL_W'(pl_s1) + {ph_s1, {HALF{1'b0}}} + FULL_W'(24'h80_0000);
	assign rnd  = full[FULL_W-1:24];

	always_ff @(posedge clk) begin
		if (en) begin
			p_mag <= (rnd > (FULL_W-24)'(PROD_LIM)) ? PROD_LIM : rnd[PMAG_W-1:0];
			p_neg <= neg_s1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/lice_recip.sv
// channel minus offset and pipelined restoring reciprocal, one quotient bit a stage
`timescale 1ns / 1ps
`default_nettype none
module lice_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  logic [lice_pkg::CH_W-1:0]   channel,
	input  logic signed [lice_pkg::OFF_W-1:0] x_offset,
	output logic                        v_out,
	output logic [lice_pkg::Q_W-1:0]    u_mag,
	output logic                        u_neg,
	output logic                        sat
);
	import lice_pkg::*;

	logic signed [D_W-1:0] d_s1;
	logic                  v_s1;
	logic [AD_W-1:0]       abs_d;

	logic [AD_W-1:0] rem_s  [0:Q_W];
	logic [Q_W-1:0]  nq_s   [0:Q_W];
	logic [AD_W-1:0] ad_s   [0:Q_W];
	logic            neg_s  [0:Q_W];
	logic            zero_s [0:Q_W];
	logic            vd_s   [0:Q_W];

	// difference in Q.8
	always_ff @(posedge clk) begin
		if (en)
			d_s1 <= $signed({2'b00, channel, 8'h00}) - D_W'(x_offset);
	end

	assign abs_d = d_s1[D_W-1] ? AD_W'(-d_s1) : AD_W'(d_s1);

	// magnitude and rounded numerator
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			nq_s[0]   <= U_NUM + Q_W'(abs_d >> 1);
			ad_s[0]   <= abs_d;
			neg_s[0]  <= d_s1[D_W-1];
			zero_s[0] <= (d_s1 == '0);
		end
	end

	// valid chain of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			vd_s[0]  <= 1'b0;
		end else if (en) begin
			v_s1     <= v_in;
			vd_s[0]  <= v_s1;
		end
	end

	// divider stages
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic [AD_W:0] trial;
		logic          ge;
		logic [AD_W:0] diff;

		assign trial = {rem_s[j], nq_s[j][Q_W-1]};
		assign ge    = trial >= {1'b0, ad_s[j]};
		assign diff  = trial - {1'b0, ad_s[j]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? diff[AD_W-1:0] : trial[AD_W-1:0];
				nq_s[j+1]   <= {nq_s[j][Q_W-2:0], ge};
				ad_s[j+1]   <= ad_s[j];
				neg_s[j+1]  <= neg_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vd_s[j+1] <= 1'b0;
			else if (en)
				vd_s[j+1] <= vd_s[j];
		end
	end

	// saturation of u at the largest positive value
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[Q_W] || (!neg_s[Q_W] && nq_s[Q_W][Q_W-1])) begin
				u_mag <= U_MAX;
				u_neg <= 1'b0;
				sat   <= 1'b1;
			end else begin
				u_mag <= nq_s[Q_W];
				u_neg <= neg_s[Q_W];
				sat   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out <= 1'b0;
		else if (en)
			v_out <= vd_s[Q_W];
	end

endmodule
`default_nettype wire

FILE: rtl/core/lice_term.sv
// one polynomial step: next power of u, its coefficient product, running sum
`timescale 1ns / 1ps
`default_nettype none
module lice_term (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         v_in,
	input  lice_pkg::poly_t              in,
	input  logic [lice_pkg::CMAG_W-1:0]  c_mag,
	input  logic                         c_neg,
	output logic                         v_out,
	output lice_pkg::poly_t              out
);
	import lice_pkg::*;

	poly_t             d_s1, d_s2, d_s3, d_s4;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [PMAG_W-1:0] pk_mag;
	logic              pk_neg;
	logic [PMAG_W-1:0] tk_mag;
	logic              tk_neg;
	poly_t             in_fold;
	poly_t             pow_join;

	// p_k = p_(k-1) * u
	lice_mul u_pow (
		.clk   (clk),
		.en    (en),
		.a_mag (in.p_mag),
		.a_neg (in.p_neg),
		.b_mag (in.u_mag),
		.b_neg (in.u_neg),
		.p_mag (pk_mag),
		.p_neg (pk_neg)
	);

	// term = c_k * p_k
	lice_mul u_coef (
		.clk   (clk),
		.en    (en),
		.a_mag (pk_mag),
		.a_neg (pk_neg),
		.b_mag ({1'b0, c_mag}),
		.b_neg (c_neg),
		.p_mag (tk_mag),
		.p_neg (tk_neg)
	);

	// previous term folded into the sum, new power joined to its side values
	always_comb begin
		in_fold          = in;
		in_fold.acc      = add_term(in.acc, in.t_mag, in.t_neg);
		pow_join         = d_s2;
		pow_join.p_mag   = pk_mag;
		pow_join.p_neg   = pk_neg;
	end

	// side values delayed alongside the multipliers
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= in_fold;
			d_s2 <= d_s1;
			d_s3 <= pow_join;
			d_s4 <= d_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		out       = d_s4;
		out.t_mag = tk_mag;
		out.t_neg = tk_neg;
	end

	assign v_out = v_s4;

endmodule
`default_nettype wire

FILE: rtl/core/lice_exp.sv
// pipelined exp of a Q.24 argument to Q16.16: range reduction, Taylor series, scaling
`timescale 1ns / 1ps
`default_nettype none
module lice_exp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             v_in,
	input  logic signed [lice_pkg::ARG_W-1:0] arg,
	input  logic                             sat_in,
	output logic                             v_out,
	output logic [lice_pkg::VAL_W-1:0]       value,
	output logic                             overflow
);
	import lice_pkg::*;

	localparam int NT = 16;
	localparam logic signed [36:0] LN2_S = 37'(LN2_Q30);

	typedef struct packed {
		logic signed [6:0] n;
		logic [29:0]       r;
		logic              sat;
	} side_t;

	// range reduction registers
	logic signed [39:0] nprod;
	logic signed [6:0]  n_s1, n_s2;
	logic signed [35:0] a30_s1;
	logic signed [36:0] r0_s2;
	logic               sat_s1, sat_s2;
	logic               v_s1, v_s2, v_s3;
	side_t              side_s3;
	side_t              side_nx;

	// series registers, A computes the product, B the division by i
	logic [29:0] ta_s   [2:NT];
	logic [31:0] suma_s [2:NT];
	side_t       sa_s   [2:NT];
	logic        va_s   [2:NT];
	logic [29:0] tb_s   [2:NT];
	logic [31:0] sumb_s [2:NT];
	side_t       sb_s   [2:NT];
	logic        vb_s   [2:NT];

	// scaling registers
	logic [31:0]       sum_f0;
	side_t             side_f0;
	logic              v_f0, v_f1;
	logic [39:0]       pre_f1;
	logic              rsh_f1;
	logic [5:0]        s_f1;
	logic              sat_f1;
	logic signed [7:0] sh;
	logic [5:0]        s_amt;
	logic [39:0]       vfin;

	// estimate n from a reciprocal of ln2
	assign nprod = 40'(arg) * $signed({30'b0, LN2_RECIP});

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= nprod[38:32];
			a30_s1 <= {arg, 6'b000000};
			sat_s1 <= sat_in;
			n_s2   <= n_s1;
			r0_s2  <= 37'(a30_s1) - 37'(n_s1) * LN2_S;
			sat_s2 <= sat_s1;
		end
	end

	// bring r into [0, ln2)
	always_comb begin
		side_nx.sat = sat_s2;
		if (r0_s2 < 0) begin
			side_nx.r = 30'(r0_s2 + LN2_S);
			side_nx.n = n_s2 - 7'sd1;
		end else if (r0_s2 >= LN2_S) begin
			side_nx.r = 30'(r0_s2 - LN2_S);
			side_nx.n = n_s2 + 7'sd1;
		end else begin
			side_nx.r = 30'(r0_s2);
			side_nx.n = n_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			side_s3 <= side_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Taylor terms two to sixteen, first term is r itself
	for (genvar i = 2; i <= NT; i++) begin : g_term
		localparam logic [33:0] RECIP = 34'(((64'd1 << 34) + i - 1) / i);
		logic [29:0] term_in;
		logic [31:0] sum_in;
		side_t       side_in;
		logic        v_in_i;
		logic [59:0] mprod;
		logic [63:0] qprod;

		if (i == 2) begin : g_first
			assign term_in = side_s3.r;
			assign sum_in  = 32'h4000_0000;
			assign side_in = side_s3;
			assign v_in_i  = v_s3;
		end else begin : g_next
			assign term_in = tb_s[i-1];
			assign sum_in  = sumb_s[i-1];
			assign side_in = sb_s[i-1];
			assign v_in_i  = vb_s[i-1];
		end

		assign mprod = {30'b0, term_in} * {30'b0, side_in.r};
		assign qprod = {34'b0, ta_s[i]} * {30'b0, RECIP};

		always_ff @(posedge clk) begin
			if (en) begin
				ta_s[i]   <= mprod[59:30];
				suma_s[i] <= sum_in + 32'(term_in);
				sa_s[i]   <= side_in;
				tb_s[i]   <= qprod[63:34];
				sumb_s[i] <= suma_s[i];
				sb_s[i]   <= sa_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_s[i] <= 1'b0;
				vb_s[i] <= 1'b0;
			end else if (en) begin
				va_s[i] <= v_in_i;
				vb_s[i] <= va_s[i];
			end
		end
	end

	// last term into the sum
	always_ff @(posedge clk) begin
		if (en) begin
			sum_f0  <= sumb_s[NT] + 32'(tb_s[NT]);
			side_f0 <= sb_s[NT];
		end
	end

	// scale by 2^(n-14): left shift, or add half before the right shift
	assign sh    = 8'(side_f0.n) - 8'sd14;
	assign s_amt = 6'(-sh);

	always_ff @(posedge clk) begin
		if (en) begin
			rsh_f1 <= sh[7];
			s_f1   <= s_amt;
			sat_f1 <= side_f0.sat;
			if (sh[7])
				pre_f1 <= 40'(sum_f0) + (40'd1 << (s_amt - 6'd1));
			else
				pre_f1 <= 40'(sum_f0) << sh[3:0];
		end
	end

	assign vfin = rsh_f1 ? (pre_f1 >> s_f1) : pre_f1;

	// saturate to the Q16.16 range
	always_ff @(posedge clk) begin
		if (en) begin
			if (vfin[39:32] != '0) begin
				value    <= '1;
				overflow <= 1'b1;
			end else begin
				value    <= vfin[31:0];
				overflow <= sat_f1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f0  <= 1'b0;
			v_f1  <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_f0  <= vb_s[NT];
			v_f1  <= v_f0;
			v_out <= v_f1;
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench of the inverse-log calibration evaluator
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import lice_pkg::*;

	localparam int TERMS = 4;
	localparam int LATENCY = 73 + 4 * (TERMS - 1);
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             overflow;
	} calib_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [REG_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [CH_W-1:0]     channel;
	logic                out_valid;
	logic                out_ready;
	logic [VAL_W-1:0]    value;
	logic                overflow;

	// predictor copy of the configuration
	longint        offset_q8;
	longint        coef_q24 [NCOEF];
	calib_result_t pending_results [$];
	int            fail_count;
	longint        cycle_count;
	bit            sink_idles;
	bit            source_idles;
	int            sink_hold_req;

	log_inverse_calibration_eval #(.NUM_TERMS(TERMS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .channel(channel),
		.out_valid(out_valid), .out_ready(out_ready), .value(value),
		.overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// rounded q24 product of two signed values, magnitude saturated
	function automatic longint q24_mul(input longint a, input longint b);
		logic         neg;
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] pr;
		longint       m;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		pr = (ma * mb + (128'd1 << 23)) >> 24;
		if (pr > 128'(PROD_LIM))
			pr = 128'(PROD_LIM);
		m = longint'(pr[63:0]);
		return neg ? -m : m;
	endfunction

	// exp of a clamped q24 argument to q16.16, flags saturation
	function automatic void exp_q16(input longint arg, inout logic sat,
			output logic [VAL_W-1:0] res);
		longint      a30;
		longint      n;
		longint      ln2;
		int          sh;
		logic [63:0] r;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] v;
		ln2 = longint'(LN2_Q30);
		a30 = arg * 64;
		n = a30 / ln2;
		if ((a30 % ln2) != 0 && a30 < 0)
			n = n - 1;
		r = 64'(a30 - n * ln2);
		sum = 64'd1 << 30;
		term = sum;
		for (int i = 1; i <= 16; i++) begin
			term = ((term * r) >> 30) / 64'(i);
			sum = sum + term;
		end
		sh = int'(n) - 14;
		if (sh >= 0)
			v = sum << sh;
		else
			v = (sum + (64'd1 << (-sh - 1))) >> (-sh);
		if (v > 64'hFFFF_FFFF) begin
			sat = 1'b1;
			res = '1;
		end else begin
			res = v[31:0];
		end
	endfunction

	// expected calibrated value of one channel
	function automatic calib_result_t calibrate(input logic [CH_W-1:0] ch);
		calib_result_t res;
		longint        d;
		longint        ad;
		longint        q;
		longint        u;
		longint        p;
		longint        acc;
		longint        c;
		logic          sat;
		sat = 1'b0;
		d = longint'(ch) * 256 - offset_q8;
		if (d == 0) begin
			u = longint'(U_MAX);
			sat = 1'b1;
		end else begin
			ad = (d < 0) ? -d : d;
			q = ((64'sd1 <<< 32) + ad / 2) / ad;
			if (d > 0) begin
				if (q > longint'(U_MAX)) begin
					u = longint'(U_MAX);
					sat = 1'b1;
				end else begin
					u = q;
				end
			end else begin
				u = -q;
			end
		end
		p = longint'(Q24_ONE);
		acc = 0;
		for (int k = 0; k < TERMS; k++) begin
			c = (k < NCOEF) ? coef_q24[k] : 0;
			if (k > 0) begin
				p = q24_mul(p, u);
				acc = acc + q24_mul(c, p);
			end else begin
				acc = acc + c;
			end
		end
		if (acc > longint'(ARG_LIM))
			acc = longint'(ARG_LIM);
		if (acc < -longint'(ARG_LIM))
			acc = -longint'(ARG_LIM);
		exp_q16(acc, sat, res.value);
		res.overflow = sat;
		return res;
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		calib_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value=%h overflow=%b", $time, value,
					overflow);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (value !== exp_r.value) begin
					$display("%0t: value mismatch expected %h actual %h", $time,
						exp_r.value, value);
					fail_count++;
				end
				if (overflow !== exp_r.overflow) begin
					$display("%0t: overflow mismatch expected %b actual %b", $time,
						exp_r.overflow, overflow);
					fail_count++;
				end
			end
		end
	end

	// result sink with random stalls and an optional long hold-off
	initial begin
		int wait_cnt;
		wait_cnt = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_req > 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold_req) @(posedge clk);
				sink_hold_req = 0;
				out_ready <= 1'b1;
			end else if (out_ready && out_valid) begin
				wait_cnt = sink_idles ? $urandom_range(0, 12) : 0;
				if (wait_cnt > 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (wait_cnt > 0)
					wait_cnt--;
				if (wait_cnt == 0)
					out_ready <= 1'b1;
			end
		end
	end

	// one channel transaction, with a random gap before it
	task automatic send_channel(input logic [CH_W-1:0] ch);
		int gap;
		gap = source_idles ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(calibrate(ch));
	endtask

	// wait for the pipeline to empty before touching the registers
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// one register write, valid dropped for a cycle afterwards
	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_X_OFFSET)
			offset_q8 = longint'($signed(data[OFF_W-1:0]));
		else if (idx >= REG_COEF_0 && idx <= REG_COEF_3)
			coef_q24[idx - REG_COEF_0] = longint'($signed(data));
		@(posedge clk);
	endtask

	task automatic write_all(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] c0,
			input logic [CFG_W-1:0] c1, input logic [CFG_W-1:0] c2,
			input logic [CFG_W-1:0] c3);
		drain();
		write_reg(REG_X_OFFSET, off);
		write_reg(REG_COEF_0, c0);
		write_reg(REG_COEF_1, c1);
		write_reg(REG_COEF_2, c2);
		write_reg(REG_COEF_3, c3);
	endtask

	function automatic logic [CFG_W-1:0] rand_coef;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return CFG_W'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
			2: return CFG_W'(int'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000);
			3: return 0;
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_offset;
		case ($urandom_range(0, 2))
			0: return CFG_W'($urandom & 32'h00FF_FFFF);
			1: return CFG_W'(int'($urandom_range(0, 65535)) * 256 +
				int'($urandom_range(0, 1024)) - 512);
			default: return CFG_W'(int'($urandom_range(0, 255)) * 256);
		endcase
	endfunction

	// channels spread over the range or close to the offset, where u is large
	function automatic logic [CH_W-1:0] rand_channel;
		int base;
		base = int'(offset_q8 / 256) + int'($urandom_range(0, 6)) - 3;
		if ($urandom_range(0, 1) || base < 0 || base > 65535)
			return CH_W'($urandom);
		return CH_W'(base);
	endfunction

	// field extremes, saturation corners and unknown register indexes
	task automatic test_directed;
		write_all(0, 0, 0, 0, 0);
		send_channel(16'h0000);
		send_channel(16'hFFFF);
		send_channel(16'h0001);
		write_all(1, 32'h0100_0000, 32'h0100_0000, 0, 0);
		send_channel(16'h0000);
		send_channel(16'h0001);
		write_all(255, 0, 32'h0000_1000, 32'h0000_0010, 32'h0000_0001);
		send_channel(16'h0001);
		send_channel(16'h0000);
		send_channel(16'h5555);
		write_all(0, 32'h1000_0000, 0, 0, 0);
		send_channel(16'h0100);
		write_all(0, 32'hF000_0000, 0, 0, 0);
		send_channel(16'h0100);
		write_all(32'h007F_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000);
		send_channel(16'hFFFF);
		send_channel(16'h8000);
		send_channel(16'h7FFF);
		write_all(32'h0080_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF);
		send_channel(16'h0000);
		send_channel(16'hAAAA);
		// writes to unknown indexes must leave the registers alone
		drain();
		for (int i = REG_COEF_3 + 1; i < (1 << REG_W); i++)
			write_reg(REG_W'(i), $urandom);
		send_channel(16'h1234);
		send_channel(16'hFFFF);
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 12; ph++) begin
			write_all(rand_offset(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
			source_idles = ph % 3 != 0;
			sink_idles = ph % 4 != 1;
			for (int i = 0; i < 130; i++)
				send_channel(rand_channel());
		end
		source_idles = 1'b1;
		sink_idles = 1'b1;
	endtask

	// sink holds off while the source streams, so the pipeline fills
	task automatic test_backpressure;
		write_all(rand_offset(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
		source_idles = 1'b0;
		sink_hold_req = 300;
		for (int i = 0; i < 200; i++)
			send_channel(rand_channel());
		source_idles = 1'b1;
	endtask

	// source pauses until every result is back, then resumes
	task automatic test_pause;
		for (int i = 0; i < 20; i++)
			send_channel(rand_channel());
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 20; i++)
			send_channel(rand_channel());
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		sink_idles = 1'b1;
		source_idles = 1'b1;
		sink_hold_req = 0;
		offset_q8 = 0;
		for (int i = 0; i < NCOEF; i++)
			coef_q24[i] = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		channel = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_pause();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
